[rtl/core/jqs_pkg.sv]
// Shared types, widths and the standard JPEG quantization tables for the
// quality scaler. No dependencies; every other file in rtl/core imports this.
package jqs_pkg;

   localparam int WORD_INDEX_W     = 4;
   localparam int POS_W            = 6;
   localparam int QUAL_W           = 17;
   localparam int ENTRY_W          = 8;
   localparam int ENTRIES_PER_WORD = 4;
   localparam int WORD_W           = ENTRY_W * ENTRIES_PER_WORD;
   localparam int LANES            = 2 * ENTRIES_PER_WORD;
   localparam int FRAC_SHIFT       = 11;
   localparam int DIVIDEND_W       = ENTRY_W + FRAC_SHIFT;
   localparam int QUO_W            = 9;
   localparam int STEPS            = QUO_W;
   localparam int WIDE_W           = QUAL_W + QUO_W;
   localparam int LATENCY          = STEPS + 2;

   localparam logic [QUAL_W-1:0]  QUALITY_RESET = QUAL_W'(1024);
   localparam logic [ENTRY_W-1:0] ENTRY_MAX     = 8'd255;
   localparam logic [ENTRY_W-1:0] ENTRY_MIN     = 8'd1;

   localparam logic [ENTRY_W-1:0] LUMA_ROM [64] = '{
      8'd16, 8'd11, 8'd10, 8'd16, 8'd24,  8'd40,  8'd51,  8'd61,
      8'd12, 8'd12, 8'd14, 8'd19, 8'd26,  8'd58,  8'd60,  8'd55,
      8'd14, 8'd13, 8'd16, 8'd24, 8'd40,  8'd57,  8'd69,  8'd56,
      8'd14, 8'd17, 8'd22, 8'd29, 8'd51,  8'd87,  8'd80,  8'd62,
      8'd18, 8'd22, 8'd37, 8'd56, 8'd68,  8'd109, 8'd103, 8'd77,
      8'd24, 8'd35, 8'd55, 8'd64, 8'd81,  8'd104, 8'd113, 8'd92,
      8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
      8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
   };

   localparam logic [ENTRY_W-1:0] CHROMA_ROM [64] = '{
      8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
      8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
   };

   typedef struct packed {
      logic                    valid;
      logic [WORD_INDEX_W-1:0] word_index;
   } tag_type;

   typedef struct packed {
      logic             sat;
      logic [QUO_W-1:0] quotient;
   } lane_result_type;

endpackage

[rtl/core/jqs_lane.sv]
// One divider lane: a pipelined restoring divider, one quotient bit per stage.
// Depends on jqs_pkg.
module jqs_lane (
   input  logic                            clock,
   input  logic [jqs_pkg::QUAL_W-1:0]      quality,
   input  logic [jqs_pkg::DIVIDEND_W-1:0]  dividend,
   output jqs_pkg::lane_result_type        result
);
   import jqs_pkg::*;

   logic [DIVIDEND_W-1:0] rem_ff   [STEPS+1];
   logic [DIVIDEND_W-1:0] rem_in   [STEPS+1];
   logic [QUO_W-1:0]      quo_ff   [STEPS+1];
   logic [QUO_W-1:0]      quo_in   [STEPS+1];
   logic                  sat_ff   [STEPS+1];
   logic                  sat_in   [STEPS+1];
   logic [WIDE_W-1:0]     shift_q  [STEPS+1];
   logic                  fits     [STEPS+1];

   // Stage zero flags quotients of 512 or more, which clamp to 255 unless the quality is zero.
   // Each later stage tries one shifted copy of the divisor, high bit first.
   always_comb begin
      rem_in[0]  = dividend;
      quo_in[0]  = '0;
      sat_in[0]  = WIDE_W'(dividend) >= (WIDE_W'(quality) << QUO_W);
      shift_q[0] = '0;
      fits[0]    = 1'b0;
      for (int s = 1; s <= STEPS; s++) begin
         shift_q[s] = WIDE_W'(quality) << (STEPS - s);
         fits[s]    = WIDE_W'(rem_ff[s-1]) >= shift_q[s];
         rem_in[s]  = fits[s] ? rem_ff[s-1] - shift_q[s][DIVIDEND_W-1:0] : rem_ff[s-1];
         quo_in[s]  = quo_ff[s-1] | (QUO_W'(fits[s]) << (STEPS - s));
         sat_in[s]  = sat_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign result.sat      = sat_ff[STEPS];
   assign result.quotient = quo_ff[STEPS];

endmodule

[rtl/core/jqs_merge.sv]
// Merge stage: rounds and clamps the eight lane quotients, applies the
// zero-quality rule and packs the luma and chroma words. Depends on jqs_pkg.
module jqs_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  jqs_pkg::tag_type                   tag,
   input  logic                               qual_zero,
   input  jqs_pkg::lane_result_type           lane_results [jqs_pkg::LANES],
   output logic                               rsp_valid,
   output logic [jqs_pkg::WORD_INDEX_W-1:0]   rsp_word_number,
   output logic [jqs_pkg::WORD_W-1:0]         rsp_luma_word,
   output logic [jqs_pkg::WORD_W-1:0]         rsp_chroma_word
);
   import jqs_pkg::*;

   logic                    valid_ff;
   logic [WORD_INDEX_W-1:0] number_ff;
   logic [WORD_W-1:0]       luma_ff;
   logic [WORD_W-1:0]       luma_in;
   logic [WORD_W-1:0]       chroma_ff;
   logic [WORD_W-1:0]       chroma_in;
   logic [QUO_W:0]          rounded  [LANES];
   logic [ENTRY_W-1:0]      entry    [LANES];
   logic                    first_entry;

   always_comb begin
      luma_in     = '0;
      chroma_in   = '0;
      first_entry = (tag.word_index == '0);
      for (int l = 0; l < LANES; l++) begin
         rounded[l] = ((QUO_W+1)'(lane_results[l].quotient) + 1'b1) >> 1;
         if (qual_zero) begin
            if (first_entry && (l % ENTRIES_PER_WORD) == 0) begin
               entry[l] = (l < ENTRIES_PER_WORD) ? LUMA_ROM[0] : CHROMA_ROM[0];
            end else begin
               entry[l] = ENTRY_MIN;
            end
         end else if (lane_results[l].sat || rounded[l] > (QUO_W+1)'(ENTRY_MAX)) begin
            entry[l] = ENTRY_MAX;
         end else if (rounded[l] == '0) begin
            entry[l] = ENTRY_MIN;
         end else begin
            entry[l] = rounded[l][ENTRY_W-1:0];
         end
         if (l < ENTRIES_PER_WORD) begin
            luma_in[(ENTRIES_PER_WORD-1-(l % ENTRIES_PER_WORD))*ENTRY_W +: ENTRY_W] = entry[l];
         end else begin
            chroma_in[(ENTRIES_PER_WORD-1-(l % ENTRIES_PER_WORD))*ENTRY_W +: ENTRY_W] = entry[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      number_ff <= tag.word_index;
      luma_ff   <= luma_in;
      chroma_ff <= chroma_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_word_number = number_ff;
   assign rsp_luma_word   = luma_ff;
   assign rsp_chroma_word = chroma_ff;

endmodule

[rtl/core/jpeg_quant_table_quality_scaler_unit.sv]
// Top level of the JPEG quantization table quality scaler.
// Depends on jqs_pkg, jqs_lane and jqs_merge.

// The unit scales the standard JPEG luma and chroma quantization tables by
// the quality register (unsigned, 10 fraction bits, 1024 means unchanged).
// A request beat names one word of four table entries; the response beat
// carries that word of both scaled tables, first entry in the top byte.
// busy is never raised, so a request is taken every cycle, and each
// response is held on the rsp_ ports for one cycle while rsp_valid is high.
// The receiver has no way to stall; it must take every response beat as
// it appears. The pipeline is formed by the eight divider lanes, which
// resolve one quotient bit per stage over nine stages, plus one stage for
// table lookup and overflow detection and one for rounding, clamping and
// packing. Write csr_quality only when no requests are in flight.
module jpeg_quant_table_quality_scaler_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [jqs_pkg::WORD_INDEX_W-1:0]   req_word_index,
   output logic                               rsp_valid,
   output logic [jqs_pkg::WORD_INDEX_W-1:0]   rsp_word_number,
   output logic [jqs_pkg::WORD_W-1:0]         rsp_luma_word,
   output logic [jqs_pkg::WORD_W-1:0]         rsp_chroma_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [jqs_pkg::QUAL_W-1:0]         csr_quality
);
   import jqs_pkg::*;

   logic [QUAL_W-1:0]     quality_ff;
   logic [QUAL_W-1:0]     quality_in;
   tag_type               tag_ff [STEPS+1];
   tag_type               tag_in [STEPS+1];
   logic [DIVIDEND_W-1:0] dividend [LANES];
   lane_result_type       lane_results [LANES];

   // The pipeline never stalls, so requests and register writes are always taken.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      quality_in = csr_valid ? csr_quality : quality_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_ff <= QUALITY_RESET;
      end else begin
         quality_ff <= quality_in;
      end
   end

   // The tag (valid and word index) travels alongside the lanes so it lines
   // up with the quotients when they reach the merge stage.
   always_comb begin
      tag_in[0].valid      = start && !busy;
      tag_in[0].word_index = req_word_index;
      for (int s = 1; s <= STEPS; s++) begin
         tag_in[s] = tag_ff[s-1];
      end
   end

   // Only the valid bits are reset; the word index simply follows along.
   always_ff @(posedge clock) begin
      for (int s = 0; s <= STEPS; s++) begin
         tag_ff[s].word_index <= tag_in[s].word_index;
         if (reset) begin
            tag_ff[s].valid <= 1'b0;
         end else begin
            tag_ff[s].valid <= tag_in[s].valid;
         end
      end
   end

   // Lanes 0 to 3 handle the luma entries of the word and lanes 4 to 7 the
   // chroma entries. Each default is scaled up by 2^11 to form the dividend.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [POS_W-1:0]   pos;
      logic [ENTRY_W-1:0] default_entry;

      assign pos           = {req_word_index, 2'(l % ENTRIES_PER_WORD)};
      assign default_entry = (l < ENTRIES_PER_WORD) ? LUMA_ROM[pos] : CHROMA_ROM[pos];
      assign dividend[l]   = DIVIDEND_W'(default_entry) << FRAC_SHIFT;

      jqs_lane u_lane (
         .clock    (clock),
         .quality  (quality_ff),
         .dividend (dividend[l]),
         .result   (lane_results[l])
      );
   end

   jqs_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .tag             (tag_ff[STEPS]),
      .qual_zero       (quality_ff == '0),
      .lane_results    (lane_results),
      .rsp_valid       (rsp_valid),
      .rsp_word_number (rsp_word_number),
      .rsp_luma_word   (rsp_luma_word),
      .rsp_chroma_word (rsp_chroma_word)
   );

   // Every response beat comes from a request that was taken earlier.
   a_rsp_from_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response beat without a matching request");

   // The echoed word number follows its own request through the pipeline.
   a_rsp_number : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word_number == $past(req_word_index, LATENCY))
      else $error("response word number does not match its request");

   // Clamping and the zero-quality rule never let an entry reach zero.
   a_luma_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luma_word[31:24] != 8'd0) && (rsp_luma_word[23:16] != 8'd0)
                 && (rsp_luma_word[15:8] != 8'd0) && (rsp_luma_word[7:0] != 8'd0))
      else $error("luma entry of zero");

   a_chroma_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chroma_word[31:24] != 8'd0) && (rsp_chroma_word[23:16] != 8'd0)
                 && (rsp_chroma_word[15:8] != 8'd0) && (rsp_chroma_word[7:0] != 8'd0))
      else $error("chroma entry of zero");

endmodule
